FILE: sv/mwm_pkg.sv
// Shared types and constants of the mecanum wheel mixer.
package mwm_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_COEFF_TRANSLATE = 3'd0;
  localparam logic [2:0] REG_COEFF_ROTATE    = 3'd1;
  localparam logic [2:0] REG_SLEW_ENABLE     = 3'd2;
  localparam logic [2:0] REG_MAX_STEP        = 3'd3;
  localparam logic [2:0] REG_WHEEL_REVERSE   = 3'd4;
  localparam logic [2:0] REG_DUTY_LIMIT      = 3'd5;

  localparam int CFG_DATA_BITS = 23;
  localparam int STEP_BITS     = 23;
  localparam int DUTY_BITS     = 15;
  localparam int LIM_BITS      = 14;

  localparam logic signed [15:0] RST_COEFF_TRANSLATE = 16'sd579;
  localparam logic signed [15:0] RST_COEFF_ROTATE    = 16'sd16066;
  localparam logic [22:0]        RST_MAX_STEP        = 23'd12800;
  localparam logic [3:0]         RST_WHEEL_REVERSE   = 4'd5;
  localparam logic [5:0]         RST_DUTY_LIMIT      = 6'd48;

  localparam logic [14:0] DUTY_MID   = 15'd12800;
  localparam logic [5:0]  LIMIT_CAP  = 6'd50;
  localparam int          OFF_MUL    = 7;
  localparam int          OFF_DEN    = 60;
  localparam int          OFF_BIAS   = 30;

  // Quotient bit counts of the slew and duty scaling divisions.
  localparam int K_SLEW = 23;
  localparam int K_DUTY = 14;

  // Division kinds.
  localparam logic [1:0] KIND_SLEW = 2'd0;
  localparam logic [1:0] KIND_OFF  = 2'd1;
  localparam logic [1:0] KIND_DUTY = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       mul;
    logic       mix;
    logic       copy;
    logic       off_load;
    logic       div_start;
    logic       div_take;
    logic [1:0] kind;
    logic [1:0] wheel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic slew_hit;
    logic limit_hit;
  } dp_sts_t;

endpackage

FILE: sv/mwm_divider.sv
// Restoring divider, one quotient bit per cycle, quotient length set by the division kind.
module mwm_divider #(
  parameter int NW    = 72,
  parameter int DW    = 25,
  parameter int QW    = 23
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          kind,
  input  logic [NW-1:0]       num,
  input  logic [DW-1:0]       den,
  output logic [QW-1:0]       quo,
  output logic                busy
);
  import mwm_pkg::*;

  localparam int CW = $clog2(QW + 1);

  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [CW-1:0] cnt;

  assign busy = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      case (kind)
        KIND_SLEW: cnt <= CW'(K_SLEW);
        default:   cnt <= CW'(K_DUTY);
      endcase
    end else if (busy) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      quo <= '0;
      case (kind)
        KIND_SLEW: dsh <= NW'(den) << (K_SLEW - 1);
        default:   dsh <= NW'(den) << (K_DUTY - 1);
      endcase
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        quo <= {quo[QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("divider started while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("divider did not start");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (busy && !start) |=> (cnt == $past(cnt) - CW'(1)))
    else $error("divider count skipped");

endmodule

FILE: sv/mwm_datapath.sv
// Mixing, slew limiting and duty scaling datapath with the stored wheel speeds.
module mwm_datapath #(
  parameter int SPEED_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mwm_pkg::dp_cmd_t      cmd,
  output mwm_pkg::dp_sts_t      sts,
  input  logic signed [15:0]    vel_x,
  input  logic signed [15:0]    vel_y,
  input  logic signed [15:0]    vel_rot,
  input  logic signed [15:0]    coeff_translate,
  input  logic signed [15:0]    coeff_rotate,
  input  logic                  slew_enable,
  input  logic [22:0]           max_step,
  input  logic [3:0]            wheel_reverse,
  input  logic [5:0]            duty_limit,
  output logic [14:0]           duty_front_left,
  output logic [14:0]           duty_front_right,
  output logic [14:0]           duty_back_left,
  output logic [14:0]           duty_back_right,
  output logic                  duty_scaled
);
  import mwm_pkg::*;

  localparam int TB  = SPEED_BITS + 8;
  localparam int DW  = TB + 1;
  localparam int OMW = TB - 3;
  localparam int QW  = (TB - 3 > K_SLEW) ? TB - 3 : K_SLEW;
  localparam int NW  = DW + QW;
  localparam int XW  = TB + 34;
  localparam int CW  = (DW > STEP_BITS) ? DW : STEP_BITS;

  // Offset numerator width and the reciprocal of the offset divisor.
  localparam int     ONW     = TB + 2;
  localparam int     RK      = ONW + 6;
  localparam longint RECIP_L = ((longint'(1) << RK) + longint'(OFF_DEN) - 1) /
                               longint'(OFF_DEN);
  localparam logic [ONW:0] RECIP = RECIP_L[ONW:0];

  localparam logic signed [XW-1:0] SMAX_X = (XW'(1) <<< (TB - 1)) - XW'(1);
  localparam logic signed [XW-1:0] SMIN_X = -SMAX_X - XW'(1);
  localparam logic signed [TB-1:0] SMAX_T = TB'(SMAX_X);
  localparam logic signed [TB-1:0] SMIN_T = TB'(SMIN_X);

  logic signed [15:0]   x, y, r;
  logic signed [31:0]   rt, xt, yt;
  logic signed [TB-1:0] spd   [4];
  logic signed [TB-1:0] last  [4];
  logic signed [DW-1:0] delta [4];
  logic [DW-1:0]        dmax;
  logic [OMW-1:0]       off_mag [4];
  logic [3:0]           off_neg;
  logic [OMW-1:0]       pmax;

  // Mixing of one wheel.
  logic signed [33:0]   raw;
  logic signed [XW-1:0] mix_sh;
  logic signed [TB-1:0] spd_new;
  logic signed [DW-1:0] delta_new;
  logic [DW-1:0]        delta_new_mag;

  always_comb begin
    raw = 34'(rt) + (cmd.wheel[1] ? -34'(xt) : 34'(xt))
                  + (cmd.wheel[0] ? -34'(yt) : 34'(yt));
    mix_sh = (XW'(raw) + XW'(32)) >>> 6;
    if (mix_sh > SMAX_X) begin
      spd_new = SMAX_T;
    end else if (mix_sh < SMIN_X) begin
      spd_new = SMIN_T;
    end else begin
      spd_new = TB'(mix_sh);
    end
    delta_new = DW'(spd_new) - DW'(last[cmd.wheel]);
    delta_new_mag = delta_new[DW-1] ? DW'(-delta_new) : DW'(delta_new);
  end

  // Division operands.
  logic [DW-1:0]           dsel_mag;
  logic [DW+STEP_BITS-1:0] prod_slew;
  logic signed [TB-1:0]    s_rev;
  logic                    s_neg;
  logic [TB-1:0]           s_mag;
  logic [5:0]              dl_cap;
  logic [LIM_BITS-1:0]     lim;
  logic [OMW+LIM_BITS-1:0] prod_duty;
  logic [NW-1:0]           div_num;
  logic [DW-1:0]           div_den;
  logic [QW-1:0]           quo;
  logic                    div_busy;

  // Offset division by a constant, done as a registered reciprocal multiplication.
  logic [ONW-1:0]          off_num;
  logic                    off_sgn;
  logic [2*ONW:0]          off_prod;
  logic [OMW-1:0]          off_q;

  always_comb begin
    dsel_mag  = delta[cmd.wheel][DW-1] ? DW'(-delta[cmd.wheel]) : DW'(delta[cmd.wheel]);
    prod_slew = dsel_mag * max_step;
    if (wheel_reverse[cmd.wheel]) begin
      s_rev = (last[cmd.wheel] == SMIN_T) ? SMAX_T : -last[cmd.wheel];
    end else begin
      s_rev = last[cmd.wheel];
    end
    s_neg  = s_rev[TB-1];
    s_mag  = s_neg ? TB'(-s_rev) : TB'(s_rev);
    dl_cap = (duty_limit > LIMIT_CAP) ? LIMIT_CAP : duty_limit;
    lim    = {dl_cap, 8'b0};
    prod_duty = off_mag[cmd.wheel] * lim;
    off_prod  = off_num * RECIP;
    off_q     = OMW'(off_prod >> RK);
    case (cmd.kind)
      KIND_SLEW: begin
        div_num = NW'(prod_slew) + NW'(dmax >> 1);
        div_den = dmax;
      end
      default: begin
        div_num = NW'(prod_duty) + NW'(pmax >> 1);
        div_den = DW'(pmax);
      end
    endcase
  end

  mwm_divider #(
    .NW(NW), .DW(DW), .QW(QW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .kind  (cmd.kind),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .busy  (div_busy)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x <= vel_x;
      y <= vel_y;
      r <= vel_rot;
      dmax <= '0;
      pmax <= '0;
    end
    if (cmd.mul) begin
      rt <= coeff_rotate * r;
      xt <= coeff_translate * x;
      yt <= coeff_translate * y;
    end
    if (cmd.mix) begin
      spd[cmd.wheel]   <= spd_new;
      delta[cmd.wheel] <= delta_new;
      if (delta_new_mag > dmax) dmax <= delta_new_mag;
    end
    if (cmd.off_load) begin
      off_num <= ONW'(s_mag) * ONW'(OFF_MUL) + ONW'(OFF_BIAS);
      off_sgn <= s_neg;
    end
    if (cmd.div_take && cmd.kind == KIND_OFF) begin
      off_mag[cmd.wheel] <= off_q;
      off_neg[cmd.wheel] <= off_sgn;
      if (off_q > pmax) pmax <= off_q;
    end
    if (cmd.div_take && cmd.kind == KIND_DUTY) begin
      off_mag[cmd.wheel] <= OMW'(quo);
    end
  end

  // Stored speeds are the block state and clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) last[i] <= '0;
    end else if (cmd.copy) begin
      for (int i = 0; i < 4; i++) last[i] <= spd[i];
    end else if (cmd.div_take && cmd.kind == KIND_SLEW) begin
      // The step never passes the new speed, so it stays in range.
      last[cmd.wheel] <= delta[cmd.wheel][DW-1] ? last[cmd.wheel] - TB'(quo)
                                                : last[cmd.wheel] + TB'(quo);
    end
  end

  always_comb begin
    sts.div_busy  = div_busy;
    sts.slew_hit  = slew_enable && (CW'(dmax) >= CW'(max_step)) && (dmax != '0);
    sts.limit_hit = (pmax >= OMW'(lim)) && (pmax != '0);
  end

  function automatic logic [14:0] duty_of(input logic neg, input logic [OMW-1:0] m);
    duty_of = neg ? DUTY_MID - DUTY_BITS'(m) : DUTY_MID + DUTY_BITS'(m);
  endfunction

  assign duty_front_left  = duty_of(off_neg[0], off_mag[0]);
  assign duty_front_right = duty_of(off_neg[1], off_mag[1]);
  assign duty_back_left   = duty_of(off_neg[2], off_mag[2]);
  assign duty_back_right  = duty_of(off_neg[3], off_mag[3]);
  assign duty_scaled      = sts.limit_hit;

endmodule

FILE: sv/mwm_ctrl.sv
// Sequencer that walks the four wheels through mixing, slew, offset and scaling steps.
module mwm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  output logic              out_load,
  input  mwm_pkg::dp_sts_t  sts,
  output mwm_pkg::dp_cmd_t  cmd
);
  import mwm_pkg::*;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_MUL        = 4'd1;
  localparam logic [3:0] S_MIX        = 4'd2;
  localparam logic [3:0] S_DECIDE     = 4'd3;
  localparam logic [3:0] S_SLEW_GO    = 4'd4;
  localparam logic [3:0] S_SLEW_WAIT  = 4'd5;
  localparam logic [3:0] S_OFF_GO     = 4'd6;
  localparam logic [3:0] S_OFF_WAIT   = 4'd7;
  localparam logic [3:0] S_LIMIT      = 4'd8;
  localparam logic [3:0] S_SCALE_GO   = 4'd9;
  localparam logic [3:0] S_SCALE_WAIT = 4'd10;
  localparam logic [3:0] S_DONE       = 4'd11;

  logic [3:0] state, state_next;
  logic [1:0] wheel, wheel_next;

  always_comb begin
    state_next = state;
    wheel_next = wheel;
    cmd        = '0;
    cmd.wheel  = wheel;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        wheel_next = 2'd0;
        state_next = S_MIX;
      end
      S_MIX: begin
        cmd.mix    = 1'b1;
        wheel_next = wheel + 2'd1;
        if (wheel == 2'd3) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.slew_hit) begin
          state_next = S_SLEW_GO;
        end else begin
          cmd.copy   = 1'b1;
          state_next = S_OFF_GO;
        end
      end
      S_SLEW_GO: begin
        cmd.kind      = KIND_SLEW;
        cmd.div_start = 1'b1;
        state_next    = S_SLEW_WAIT;
      end
      S_SLEW_WAIT: begin
        cmd.kind = KIND_SLEW;
        if (!sts.div_busy) begin
          cmd.div_take = 1'b1;
          wheel_next   = wheel + 2'd1;
          state_next   = (wheel == 2'd3) ? S_OFF_GO : S_SLEW_GO;
        end
      end
      S_OFF_GO: begin
        cmd.kind     = KIND_OFF;
        cmd.off_load = 1'b1;
        state_next   = S_OFF_WAIT;
      end
      S_OFF_WAIT: begin
        cmd.kind     = KIND_OFF;
        cmd.div_take = 1'b1;
        wheel_next   = wheel + 2'd1;
        state_next   = (wheel == 2'd3) ? S_LIMIT : S_OFF_GO;
      end
      S_LIMIT: begin
        state_next = sts.limit_hit ? S_SCALE_GO : S_DONE;
      end
      S_SCALE_GO: begin
        cmd.kind      = KIND_DUTY;
        cmd.div_start = 1'b1;
        state_next    = S_SCALE_WAIT;
      end
      S_SCALE_WAIT: begin
        cmd.kind = KIND_DUTY;
        if (!sts.div_busy) begin
          cmd.div_take = 1'b1;
          wheel_next   = wheel + 2'd1;
          state_next   = (wheel == 2'd3) ? S_DONE : S_SCALE_GO;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        wheel_next = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wheel <= 2'd0;
    end else begin
      state <= state_next;
      wheel <= wheel_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free) else $error("result loaded into a full output stage");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (state == S_IDLE))
    else $error("finished item did not return to idle");

endmodule

FILE: sv/mecanum_wheel_mixer.sv
// Top level of the mecanum wheel mixer: configuration registers, output stage and units.
//
// Each velocity beat is multiplied, mixed for the four wheels and turned into duty offsets;
// slew limiting and the scaling down of the duty offsets add further steps when they engage.
// The slew steps and the scaled offsets are set by the single shared restoring divider, which
// produces one quotient bit per cycle for each of the four wheels in turn: 23 bits per slew
// step and 14 bits per scaled offset. The duty offsets use a reciprocal multiplication per
// wheel. Items are handled one at a time; the next beat is taken as soon as the previous
// result sits in the output register, even if it has not been taken yet.
module mecanum_wheel_mixer #(
  parameter int SPEED_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // vel_x, vel_y, vel_rot
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // duty_front_left, duty_front_right,
                                      // duty_back_left, duty_back_right, zero fill
  output logic        m_axis_tuser    // duty_scaled
);
  import mwm_pkg::*;

  logic signed [15:0] coeff_translate, coeff_rotate;
  logic               slew_enable;
  logic [22:0]        max_step;
  logic [3:0]         wheel_reverse;
  logic [5:0]         duty_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_translate <= RST_COEFF_TRANSLATE;
      coeff_rotate    <= RST_COEFF_ROTATE;
      slew_enable     <= 1'b0;
      max_step        <= RST_MAX_STEP;
      wheel_reverse   <= RST_WHEEL_REVERSE;
      duty_limit      <= RST_DUTY_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEFF_TRANSLATE: coeff_translate <= cfg_data[15:0];
        REG_COEFF_ROTATE:    coeff_rotate    <= cfg_data[15:0];
        REG_SLEW_ENABLE:     slew_enable     <= cfg_data[0];
        REG_MAX_STEP:        max_step        <= cfg_data;
        REG_WHEEL_REVERSE:   wheel_reverse   <= cfg_data[3:0];
        REG_DUTY_LIMIT:      duty_limit      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic        out_free, out_load;
  logic [14:0] d_fl, d_fr, d_bl, d_br;
  logic        d_scaled;
  logic        out_valid;
  logic [59:0] out_data;
  logic        out_user;

  assign out_free = !out_valid || m_axis_tready;

  mwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .out_load (out_load),
    .sts      (sts),
    .cmd      (cmd)
  );

  mwm_datapath #(.SPEED_BITS(SPEED_BITS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .vel_x            (s_axis_tdata[15:0]),
    .vel_y            (s_axis_tdata[31:16]),
    .vel_rot          (s_axis_tdata[47:32]),
    .coeff_translate  (coeff_translate),
    .coeff_rotate     (coeff_rotate),
    .slew_enable      (slew_enable),
    .max_step         (max_step),
    .wheel_reverse    (wheel_reverse),
    .duty_limit       (duty_limit),
    .duty_front_left  (d_fl),
    .duty_front_right (d_fr),
    .duty_back_left   (d_bl),
    .duty_back_right  (d_br),
    .duty_scaled      (d_scaled)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {d_br, d_bl, d_fr, d_fl};
      out_user <= d_scaled;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_data};
  assign m_axis_tuser  = out_user;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench of the mecanum wheel mixer: queue-fed driver, checking monitor.
module tb_top;
  import mwm_pkg::*;

  localparam int  SPD_W    = 24;
  localparam int  WD_LIMIT = 4000;
  localparam int  HOLD_LEN = 600;

  typedef struct packed {
    logic [3:0][14:0] duty;
    logic             scaled;
  } duty_set_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [22:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  // Shadow of the configuration and the stored wheel speeds.
  logic signed [15:0] gain_xy, gain_rot;
  logic               slew_on;
  logic [22:0]        step_cap;
  logic [3:0]         reverse_mask;
  logic [5:0]         limit_pct;
  longint             wheel_speed[4];

  logic [47:0] vel_q[$];
  duty_set_t   duty_q[$];
  bit          calm = 1'b0;
  int          errors = 0, n_in = 0, n_out = 0, n_cfg = 0, n_scaled = 0;
  int          gap_left = 0, stall_left = 0, hold_left = 0, quiet = 0;
  bit          hold_done = 1'b0;

  mecanum_wheel_mixer dut (.*);

  always #4 clk = ~clk;

  function automatic longint clamp_speed(longint v);
    longint hi = (longint'(1) << (SPD_W - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Rounds |num|*mul/den to nearest, ties away from zero, keeps the sign.
  function automatic longint ratio_round(longint num, longint mul, longint den);
    longint q = (abs64(num) * mul + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic void mix_wheels(logic [47:0] d);
    longint x, y, r, rt, xt, yt, lim, dmax, pmax;
    longint raw[4], spd[4], dlt[4], off[4];
    duty_set_t e;
    x = longint'($signed(d[15:0]));
    y = longint'($signed(d[31:16]));
    r = longint'($signed(d[47:32]));
    rt = longint'(gain_rot) * r;
    xt = longint'(gain_xy) * x;
    yt = longint'(gain_xy) * y;
    raw[0] = rt + xt + yt;
    raw[1] = rt + xt - yt;
    raw[2] = rt - xt + yt;
    raw[3] = rt - xt - yt;
    dmax = 0;
    for (int i = 0; i < 4; i++) begin
      spd[i] = clamp_speed((raw[i] + 32) >>> 6);
      dlt[i] = spd[i] - wheel_speed[i];
      if (abs64(dlt[i]) > dmax) dmax = abs64(dlt[i]);
    end
    for (int i = 0; i < 4; i++)
      if (slew_on && dmax >= longint'(step_cap) && dmax > 0)
        wheel_speed[i] += ratio_round(dlt[i], longint'(step_cap), dmax);
      else
        wheel_speed[i] = spd[i];
    pmax = 0;
    for (int i = 0; i < 4; i++) begin
      off[i] = reverse_mask[i] ? clamp_speed(-wheel_speed[i]) : wheel_speed[i];
      off[i] = ratio_round(off[i], 7, 60);
      if (abs64(off[i]) > pmax) pmax = abs64(off[i]);
    end
    lim = (limit_pct > LIMIT_CAP ? longint'(LIMIT_CAP) : longint'(limit_pct)) * 256;
    e.scaled = (pmax >= lim && pmax > 0);
    for (int i = 0; i < 4; i++) begin
      if (e.scaled) off[i] = ratio_round(off[i], lim, pmax);
      e.duty[i] = 15'(longint'(DUTY_MID) + off[i]);
    end
    duty_q.push_back(e);
  endfunction

  // Input driver.
  always @(posedge clk) begin
    logic nv;
    logic [47:0] nd;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        mix_wheels(s_axis_tdata);
        n_in++;
        nv = 1'b0;
        gap_left = calm ? 0 : $urandom_range(0, 9);
      end
      if (!nv) begin
        if (gap_left > 0) gap_left--;
        else if (vel_q.size() > 0) begin
          nv = 1'b1;
          nd = vel_q.pop_front();
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata  <= nd;
  end

  // Long hold-off of the receiver once traffic is under way.
  always @(posedge clk) begin
    if (!hold_done && n_out == 300) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end else if (hold_left > 0) hold_left--;
  end

  // Output monitor and checker.
  always @(posedge clk) begin
    duty_set_t e;
    logic nr;
    nr = m_axis_tready;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_out++;
        if (duty_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
          errors++;
        end else begin
          e = duty_q.pop_front();
          if (e.scaled) n_scaled++;
          for (int i = 0; i < 4; i++)
            if (m_axis_tdata[15*i +: 15] !== e.duty[i]) begin
              $display("%0t: wheel %0d duty expected %0d, got %0d", $time, i,
                       e.duty[i], m_axis_tdata[15*i +: 15]);
              errors++;
            end
          if (m_axis_tdata[63:60] !== 4'd0) begin
            $display("%0t: fill bits expected 0, got %h", $time, m_axis_tdata[63:60]);
            errors++;
          end
          if (m_axis_tuser !== e.scaled) begin
            $display("%0t: duty_scaled expected %0b, got %0b", $time, e.scaled,
                     m_axis_tuser);
            errors++;
          end
        end
        stall_left = calm ? 0 : $urandom_range(0, 9);
      end
      if (hold_left > 0) nr = 1'b0;
      else if (stall_left > 0) begin
        stall_left--;
        nr = 1'b0;
      end else nr = 1'b1;
    end
    m_axis_tready <= nr;
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet = 0;
    else quiet++;
    if (quiet >= WD_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, duty_q.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [22:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_cfg++;
    case (idx)
      REG_COEFF_TRANSLATE: gain_xy      = val[15:0];
      REG_COEFF_ROTATE:    gain_rot     = val[15:0];
      REG_SLEW_ENABLE:     slew_on      = val[0];
      REG_MAX_STEP:        step_cap     = val;
      REG_WHEEL_REVERSE:   reverse_mask = val[3:0];
      REG_DUTY_LIMIT:      limit_pct    = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [15:0] t, logic [15:0] r, logic se, logic [22:0] ms,
                         logic [3:0] rv, logic [5:0] dl);
    write_reg(REG_COEFF_TRANSLATE, 23'(t));
    write_reg(REG_COEFF_ROTATE, 23'(r));
    write_reg(REG_SLEW_ENABLE, 23'(se));
    write_reg(REG_MAX_STEP, ms);
    write_reg(REG_WHEEL_REVERSE, 23'(rv));
    write_reg(REG_DUTY_LIMIT, 23'(dl));
  endtask

  task automatic drain();
    while (vel_q.size() > 0 || s_axis_tvalid || duty_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic add_vel(logic [15:0] x, logic [15:0] y, logic [15:0] r);
    vel_q.push_back({r, y, x});
  endtask

  function automatic logic [15:0] rand_vel();
    logic [15:0] pick[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom);
      8:          return pick[$urandom_range(0, 3)];
      default:    return 16'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  initial begin
    logic [22:0] ms;
    logic [5:0]  dl;
    logic [15:0] ct, cr;
    gain_xy = RST_COEFF_TRANSLATE;
    gain_rot = RST_COEFF_ROTATE;
    slew_on = 1'b0;
    step_cap = RST_MAX_STEP;
    reverse_mask = RST_WHEEL_REVERSE;
    limit_pct = RST_DUTY_LIMIT;
    foreach (wheel_speed[i]) wheel_speed[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under reset settings: zero, field extremes, mixed signs.
    add_vel(0, 0, 0);
    add_vel(16'h7FFF, 0, 0);
    add_vel(16'h8000, 0, 0);
    add_vel(0, 16'h7FFF, 0);
    add_vel(0, 16'h8000, 0);
    add_vel(0, 0, 16'h7FFF);
    add_vel(0, 0, 16'h8000);
    add_vel(16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_vel(16'h8000, 16'h8000, 16'h8000);
    add_vel(16'h7FFF, 16'h8000, 16'h7FFF);
    add_vel(100, -50, 7);
    add_vel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();
    // Extreme gains saturate the speeds; a tiny slew step and a zero duty limit.
    set_all(16'h7FFF, 16'h8000, 1'b1, 23'd1, 4'hF, 6'd0);
    add_vel(16'h7FFF, 16'h7FFF, 16'h8000);
    add_vel(16'h8000, 16'h8000, 16'h7FFF);
    add_vel(0, 0, 0);
    add_vel(0, 0, 0);
    drain();
    // Zero step freezes the speeds; duty limit above fifty is capped.
    set_all(16'h7FFF, 16'h7FFF, 1'b1, 23'd0, 4'h0, 6'd63);
    add_vel(16'h7FFF, 16'h7FFF, 16'h7FFF);
    add_vel(1000, -1000, 0);
    drain();
    set_all(16'h4000, 16'h4000, 1'b0, 23'h7FFFFF, 4'hA, 6'd63);
    add_vel(16'h7FFF, 16'h8000, 16'h7FFF);
    add_vel(16'h8000, 16'h7FFF, 16'h8000);
    drain();

    for (int p = 0; p < 8; p++) begin
      ct = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 20000));
      cr = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 20000));
      ms = 23'($urandom_range(0, 20000));
      dl = 6'($urandom_range(0, 63));
      case (p)
        1: ms = 23'h7FFFFF;
        2: ms = 23'($urandom);
        3: dl = 6'd50;
        4: dl = 6'd63;
        5: begin ct = 16'h8000; cr = 16'h7FFF; end
        6: dl = 6'd0;
        default: ;
      endcase
      set_all(ct, cr, (p % 3 != 2), ms, 4'($urandom), dl);
      calm = (p == 3);
      for (int k = 0; k < 100; k++) add_vel(rand_vel(), rand_vel(), rand_vel());
      drain();
    end

    $display("Ran %0d velocity beats and %0d register writes; %0d results checked,",
             n_in, n_cfg, n_out);
    $display("%0d with scaled duty offsets, over slew, saturation and limit settings.",
             n_scaled);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: mecanum_wheel_mixer.f
sv/mwm_pkg.sv
sv/mwm_divider.sv
sv/mwm_datapath.sv
sv/mwm_ctrl.sv
sv/mecanum_wheel_mixer.sv
tb/tb_top.sv
